[design/nwlc_pkg.sv]
// Package with the types, constants and helper functions of the noise window level classifier.
package nwlc_pkg;

   localparam int SAMPLE_W   = 13;
   localparam int HOUR_W     = 5;
   localparam int MIN_W      = 6;
   localparam int HIST_W     = 24;
   localparam int INC_W      = 12;
   localparam int LEVEL_W    = 3;
   localparam int EVENT_W    = 2;
   localparam int AVG_W      = 13;
   localparam int NW_W       = 4;
   localparam int WH_W       = 5;
   localparam int CM_W       = 5;
   localparam int TABLE_W    = 60;
   localparam int FIELD_W    = 12;
   localparam int INH_W      = 16;
   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 60;
   localparam int NUM_LEVELS = 5;
   localparam int HW60_W     = 11;
   localparam int DEN_W      = 15;

   localparam logic [AVG_W-1:0]  AVG_MAX       = '1;
   localparam logic [HIST_W-1:0] SUM_MAX       = '1;
   localparam logic [WH_W-1:0]   DEFAULT_HOURS = 5'd6;

   localparam logic [CSR_IDX_W-1:0] CSR_NUM_WINDOWS   = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_WINDOW_HOURS  = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_CYCLE_MINUTES = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_THRESHOLDS    = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_INCREMENTS    = 3'd4;
   localparam logic [CSR_IDX_W-1:0] CSR_ENABLE_INC    = 3'd5;
   localparam logic [CSR_IDX_W-1:0] CSR_INHIBIT       = 3'd6;

   localparam logic [EVENT_W-1:0] EVENT_NONE  = 2'd0;
   localparam logic [EVENT_W-1:0] EVENT_START = 2'd1;
   localparam logic [EVENT_W-1:0] EVENT_END   = 2'd2;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_SUM,
      ST_MUL,
      ST_DIV,
      ST_GRADE,
      ST_FINISH,
      ST_RESP
   } state_type;

   typedef struct packed {
      logic [SAMPLE_W-1:0] noise_sample;
      logic                sample_ok;
      logic [HOUR_W-1:0]   hour_now;
      logic [MIN_W-1:0]    minute_now;
      logic [HOUR_W-1:0]   prev_hour;
      logic [MIN_W-1:0]    prev_minute;
      logic                tap_event;
   } req_type;

   typedef struct packed {
      logic [INC_W-1:0]   increment;
      logic [LEVEL_W-1:0] level;
      logic [EVENT_W-1:0] noise_event;
      logic               window_closed;
      logic [AVG_W-1:0]   average;
   } rsp_type;

   // Window lengths that do not divide a day fall back to six hours.
   function automatic logic [WH_W-1:0] eff_hours(input logic [WH_W-1:0] hours);
      logic [WH_W-1:0] result;
      case (hours)
         5'd1, 5'd2, 5'd3, 5'd4, 5'd6, 5'd8, 5'd12, 5'd24: result = hours;
         default: result = DEFAULT_HOURS;
      endcase
      return result;
   endfunction

   // True when the hour is a multiple of the (already legal) window length.
   function automatic logic hour_aligned(input logic [WH_W-1:0] hours,
                                         input logic [HOUR_W-1:0] hour);
      logic [31:0] mask;
      case (hours)
         5'd1:    mask = 32'hFFFF_FFFF;
         5'd2:    mask = 32'h5555_5555;
         5'd3:    mask = 32'h4924_9249;
         5'd4:    mask = 32'h1111_1111;
         5'd8:    mask = 32'h0101_0101;
         5'd12:   mask = 32'h0100_1001;
         5'd24:   mask = 32'h0100_0001;
         default: mask = 32'h4104_1041;
      endcase
      return mask[hour];
   endfunction

endpackage

[design/nwlc_stream_if.sv]
// Valid/ready channel interface carrying one item of a packed payload type.
interface nwlc_stream_if #(parameter type payload_type = logic);

   logic        valid;
   logic        ready;
   payload_type payload;

   modport source (output valid, output payload, input ready);
   modport sink   (input valid, input payload, output ready);

endinterface

[design/noise_window_level_classifier.sv]
// Top level of the noise window level classifier for one noise channel.
//
//  Channel   Direction  Payload                 Handshake
//  req_if    in         nwlc_pkg::req_type      valid/ready
//  rsp_if    out        nwlc_pkg::rsp_type      valid/ready
//  csr_*     in         index 3 b, data 60 b    write enable only
//
// An item without a window close goes from idle straight to the finish state. An item
// that closes a window first passes the sum, multiply, restoring divide (one quotient
// bit per cycle) and grade states. Synchronous reset clears the FSM, the settings and
// the channel state but not the datapath; req_if.ready is high only while idle.
// The result is held until rsp_if.ready takes it, and the next item waits until then.
module noise_window_level_classifier #(
   parameter int MAX_WINDOWS = 8
) (
   input  logic                                clock,
   input  logic                                reset,
   nwlc_stream_if.sink                         req_if,
   nwlc_stream_if.source                       rsp_if,
   input  logic                                csr_write_en,
   input  logic [nwlc_pkg::CSR_IDX_W-1:0]      csr_index,
   input  logic [nwlc_pkg::CSR_DATA_W-1:0]     csr_wdata
);

   localparam int IDX_W   = (MAX_WINDOWS > 1) ? $clog2(MAX_WINDOWS) : 1;
   localparam int SUM_W   = nwlc_pkg::HIST_W + $clog2(MAX_WINDOWS);
   localparam int NUM_W   = SUM_W + nwlc_pkg::CM_W;
   localparam int DCNT_W  = $clog2(NUM_W);

   nwlc_pkg::state_type state_ff, state_in;

   logic [nwlc_pkg::NW_W-1:0]    nw_ff;
   logic [nwlc_pkg::WH_W-1:0]    wh_ff;
   logic [nwlc_pkg::CM_W-1:0]    cm_ff;
   logic [nwlc_pkg::TABLE_W-1:0] thr_ff;
   logic [nwlc_pkg::TABLE_W-1:0] inc_tab_ff;
   logic                         en_ff;
   logic [nwlc_pkg::INH_W-1:0]   inh_cyc_ff;

   logic [nwlc_pkg::SAMPLE_W-1:0] held_ff;
   logic [nwlc_pkg::HIST_W-1:0]   wsum_ff;
   logic [nwlc_pkg::HIST_W-1:0]   hist_ff [MAX_WINDOWS];
   logic                          active_ff;
   logic [nwlc_pkg::LEVEL_W-1:0]  level_ff;
   logic [nwlc_pkg::INC_W-1:0]    held_inc_ff;
   logic [nwlc_pkg::INH_W-1:0]    inh_cnt_ff;
   logic [nwlc_pkg::AVG_W-1:0]    avg_ff;

   logic [IDX_W-1:0]             idx_ff;
   logic [nwlc_pkg::NW_W-1:0]    left_ff;
   logic [SUM_W-1:0]             acc_ff;
   logic [NUM_W-1:0]             num_ff;
   logic [nwlc_pkg::DEN_W-1:0]   den_ff;
   logic [nwlc_pkg::DEN_W-1:0]   part_ff;
   logic [DCNT_W-1:0]            dcnt_ff;
   logic                         tap_ff;
   logic                         closed_ff;
   logic [nwlc_pkg::EVENT_W-1:0] event_ff;
   nwlc_pkg::rsp_type            out_ff;

   logic                          accept;
   logic                          boundary;
   logic [nwlc_pkg::SAMPLE_W-1:0] limit;
   logic [nwlc_pkg::SAMPLE_W-1:0] new_held;
   logic [nwlc_pkg::HIST_W:0]     sum_add;
   logic [nwlc_pkg::HIST_W-1:0]   wsum_new;
   logic [nwlc_pkg::MIN_W-1:0]    tol;
   logic [nwlc_pkg::WH_W-1:0]     w_eff;
   logic [nwlc_pkg::NW_W-1:0]     n_eff;
   logic [nwlc_pkg::HW60_W-1:0]   w60;
   logic [nwlc_pkg::DEN_W:0]      trial;
   logic [nwlc_pkg::DEN_W:0]      diff;
   logic                          ge;
   logic [nwlc_pkg::LEVEL_W-1:0]  lvl;
   logic [nwlc_pkg::INC_W-1:0]    lvl_inc;
   logic [nwlc_pkg::AVG_W-1:0]    avg_sat;
   logic [nwlc_pkg::INH_W-1:0]    inh_start;
   logic [nwlc_pkg::INC_W-1:0]    inc_final;
   logic                          clear_channel;

   assign accept = req_if.valid && req_if.ready;

   // Sample latch, window sum and boundary test of the incoming item.
   always_comb begin
      limit    = {thr_ff[4*nwlc_pkg::FIELD_W +: nwlc_pkg::FIELD_W], 1'b0};
      new_held = held_ff;
      if (req_if.payload.sample_ok) begin
         new_held = (req_if.payload.noise_sample > limit) ? limit
                                                          : req_if.payload.noise_sample;
      end
      sum_add  = {1'b0, wsum_ff} + (nwlc_pkg::HIST_W + 1)'(new_held);
      wsum_new = sum_add[nwlc_pkg::HIST_W] ? nwlc_pkg::SUM_MAX
                                           : sum_add[nwlc_pkg::HIST_W-1:0];
      tol      = {cm_ff, 1'b0};
      w_eff    = nwlc_pkg::eff_hours(wh_ff);
      boundary = (req_if.payload.minute_now <= tol)
                 && nwlc_pkg::hour_aligned(w_eff, req_if.payload.hour_now)
                 && !((req_if.payload.hour_now == req_if.payload.prev_hour)
                      && (req_if.payload.prev_minute <= tol));
      if (nw_ff == '0) begin
         n_eff = nwlc_pkg::NW_W'(1);
      end else if (32'(nw_ff) > MAX_WINDOWS) begin
         n_eff = nwlc_pkg::NW_W'(MAX_WINDOWS);
      end else begin
         n_eff = nw_ff;
      end
      w60 = nwlc_pkg::HW60_W'({6'd0, w_eff} * 11'd60);
   end

   // Divider step and grading of the finished quotient.
   always_comb begin
      logic go;
      trial   = {part_ff, num_ff[NUM_W-1]};
      diff    = trial - {1'b0, den_ff};
      ge      = (trial >= {1'b0, den_ff});
      lvl     = '0;
      go      = 1'b1;
      for (int i = 0; i < nwlc_pkg::NUM_LEVELS; i++) begin
         if (go && (NUM_W'(thr_ff[i*nwlc_pkg::FIELD_W +: nwlc_pkg::FIELD_W]) <= num_ff)) begin
            lvl = lvl + nwlc_pkg::LEVEL_W'(1);
         end else begin
            go = 1'b0;
         end
      end
      lvl_inc = '0;
      for (int i = 0; i < nwlc_pkg::NUM_LEVELS; i++) begin
         if (lvl == nwlc_pkg::LEVEL_W'(i + 1)) begin
            lvl_inc = inc_tab_ff[i*nwlc_pkg::FIELD_W +: nwlc_pkg::FIELD_W];
         end
      end
      avg_sat = (num_ff > NUM_W'(nwlc_pkg::AVG_MAX)) ? nwlc_pkg::AVG_MAX
                                                     : num_ff[nwlc_pkg::AVG_W-1:0];
      inh_start = (tap_ff && (inh_cnt_ff < inh_cyc_ff)) ? inh_cyc_ff : inh_cnt_ff;
      inc_final = ((inh_start != '0) || !en_ff) ? '0 : held_inc_ff;
   end

   always_comb begin
      clear_channel = 1'b0;
      if (csr_write_en) begin
         case (csr_index)
            nwlc_pkg::CSR_NUM_WINDOWS:
               clear_channel = (csr_wdata[nwlc_pkg::NW_W-1:0] != nw_ff);
            nwlc_pkg::CSR_WINDOW_HOURS:
               clear_channel = (csr_wdata[nwlc_pkg::WH_W-1:0] != wh_ff);
            default: clear_channel = 1'b0;
         endcase
      end
   end

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         nwlc_pkg::ST_IDLE: begin
            if (req_if.valid) begin
               state_in = boundary ? nwlc_pkg::ST_SUM : nwlc_pkg::ST_FINISH;
            end
         end
         nwlc_pkg::ST_SUM: begin
            if (left_ff == '0) begin
               state_in = nwlc_pkg::ST_MUL;
            end
         end
         nwlc_pkg::ST_MUL: state_in = nwlc_pkg::ST_DIV;
         nwlc_pkg::ST_DIV: begin
            if (dcnt_ff == '0) begin
               state_in = nwlc_pkg::ST_GRADE;
            end
         end
         nwlc_pkg::ST_GRADE:  state_in = nwlc_pkg::ST_FINISH;
         nwlc_pkg::ST_FINISH: state_in = nwlc_pkg::ST_RESP;
         nwlc_pkg::ST_RESP: begin
            if (rsp_if.ready) begin
               state_in = nwlc_pkg::ST_IDLE;
            end
         end
         default: state_in = nwlc_pkg::ST_IDLE;
      endcase
   end

   always_comb begin
      req_if.ready   = (state_ff == nwlc_pkg::ST_IDLE);
      rsp_if.valid   = (state_ff == nwlc_pkg::ST_RESP);
      rsp_if.payload = out_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= nwlc_pkg::ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         nw_ff      <= nwlc_pkg::NW_W'(8);
         wh_ff      <= nwlc_pkg::DEFAULT_HOURS;
         cm_ff      <= nwlc_pkg::CM_W'(2);
         thr_ff     <= '0;
         inc_tab_ff <= '0;
         en_ff      <= 1'b1;
         inh_cyc_ff <= '0;
      end else if (csr_write_en) begin
         case (csr_index)
            nwlc_pkg::CSR_NUM_WINDOWS:   nw_ff      <= csr_wdata[nwlc_pkg::NW_W-1:0];
            nwlc_pkg::CSR_WINDOW_HOURS:  wh_ff      <= csr_wdata[nwlc_pkg::WH_W-1:0];
            nwlc_pkg::CSR_CYCLE_MINUTES: cm_ff      <= csr_wdata[nwlc_pkg::CM_W-1:0];
            nwlc_pkg::CSR_THRESHOLDS:    thr_ff     <= csr_wdata[nwlc_pkg::TABLE_W-1:0];
            nwlc_pkg::CSR_INCREMENTS:    inc_tab_ff <= csr_wdata[nwlc_pkg::TABLE_W-1:0];
            nwlc_pkg::CSR_ENABLE_INC:    en_ff      <= csr_wdata[0];
            nwlc_pkg::CSR_INHIBIT:       inh_cyc_ff <= csr_wdata[nwlc_pkg::INH_W-1:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         held_ff     <= '0;
         wsum_ff     <= '0;
         active_ff   <= 1'b0;
         level_ff    <= '0;
         held_inc_ff <= '0;
         inh_cnt_ff  <= '0;
         avg_ff      <= '0;
         for (int i = 0; i < MAX_WINDOWS; i++) begin
            hist_ff[i] <= '0;
         end
      end else if (clear_channel) begin
         held_ff     <= '0;
         wsum_ff     <= '0;
         active_ff   <= 1'b0;
         level_ff    <= '0;
         held_inc_ff <= '0;
         avg_ff      <= '0;
         for (int i = 0; i < MAX_WINDOWS; i++) begin
            hist_ff[i] <= '0;
         end
      end else begin
         case (state_ff)
            nwlc_pkg::ST_IDLE: begin
               if (accept) begin
                  held_ff <= new_held;
                  if (boundary) begin
                     for (int i = MAX_WINDOWS - 1; i >= 1; i--) begin
                        hist_ff[i] <= hist_ff[i-1];
                     end
                     hist_ff[0] <= wsum_new;
                     wsum_ff    <= '0;
                  end else begin
                     wsum_ff <= wsum_new;
                  end
               end
            end
            nwlc_pkg::ST_GRADE: begin
               avg_ff <= avg_sat;
               if (lvl != '0) begin
                  active_ff   <= 1'b1;
                  held_inc_ff <= lvl_inc;
                  level_ff    <= lvl;
               end else if (active_ff) begin
                  active_ff   <= 1'b0;
                  held_inc_ff <= '0;
                  level_ff    <= '0;
               end
            end
            nwlc_pkg::ST_FINISH: begin
               held_inc_ff <= inc_final;
               if (inh_start != '0) begin
                  inh_cnt_ff <= inh_start - nwlc_pkg::INH_W'(1);
               end
            end
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      case (state_ff)
         nwlc_pkg::ST_IDLE: begin
            if (accept) begin
               tap_ff    <= req_if.payload.tap_event;
               closed_ff <= boundary;
               event_ff  <= nwlc_pkg::EVENT_NONE;
               idx_ff    <= '0;
               left_ff   <= n_eff - nwlc_pkg::NW_W'(1);
               acc_ff    <= '0;
            end
         end
         nwlc_pkg::ST_SUM: begin
            acc_ff  <= acc_ff + SUM_W'(hist_ff[idx_ff]);
            idx_ff  <= idx_ff + IDX_W'(1);
            left_ff <= left_ff - nwlc_pkg::NW_W'(1);
         end
         nwlc_pkg::ST_MUL: begin
            num_ff  <= NUM_W'(acc_ff) * NUM_W'(cm_ff);
            den_ff  <= nwlc_pkg::DEN_W'(nwlc_pkg::DEN_W'(w60) * nwlc_pkg::DEN_W'(n_eff));
            part_ff <= '0;
            dcnt_ff <= DCNT_W'(NUM_W - 1);
         end
         nwlc_pkg::ST_DIV: begin
            part_ff <= ge ? diff[nwlc_pkg::DEN_W-1:0] : trial[nwlc_pkg::DEN_W-1:0];
            num_ff  <= {num_ff[NUM_W-2:0], ge};
            dcnt_ff <= dcnt_ff - DCNT_W'(1);
         end
         nwlc_pkg::ST_GRADE: begin
            if (lvl != '0) begin
               if (!active_ff) begin
                  event_ff <= nwlc_pkg::EVENT_START;
               end
            end else if (active_ff) begin
               event_ff <= nwlc_pkg::EVENT_END;
            end
         end
         nwlc_pkg::ST_FINISH: begin
            out_ff.increment     <= inc_final;
            out_ff.level         <= level_ff;
            out_ff.noise_event   <= event_ff;
            out_ff.window_closed <= closed_ff;
            out_ff.average       <= avg_ff;
         end
         default: ;
      endcase
   end

endmodule
